// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the load protection controller.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define LPC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LPC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LPC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define LPC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ----- rtl/core/lpc_pkg.sv -----
// ----------------------------------------------------------------------------
// lpc_pkg
// Types, codes and constants of the load protection controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lpc_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 23;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_VOLTAGE_LIMIT   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CURRENT_LIMIT   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_POWER_ABS_LIMIT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_POWER_CONT_LIMIT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_TEMP_TRIP       = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_TEMP_CLEAR      = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_POWER_TRIP_TICKS = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_TEMP_SAMPLE_TICKS = 3'd7;

  // Commands.
  localparam logic [1:0] CMD_TICK        = 2'd0;
  localparam logic [1:0] CMD_SET_CURRENT = 2'd1;
  localparam logic [1:0] CMD_ENABLE      = 2'd2;
  localparam logic [1:0] CMD_CLEAR       = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_REJECTED = 2'd1;
  localparam logic [1:0] ST_DAC_FAIL = 2'd2;

  // Modes.
  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_IDLE  = 2'd1;
  localparam logic [1:0] MODE_CC    = 2'd2;
  localparam logic [1:0] MODE_FAULT = 2'd3;

  // Fault word bit positions.
  localparam int FB_REV    = 0;
  localparam int FB_OVHW   = 1;
  localparam int FB_OVSW   = 2;
  localparam int FB_OC     = 3;
  localparam int FB_POWER  = 4;
  localparam int FB_OTEMP  = 5;
  localparam int FB_SENSOR = 6;
  localparam int FB_DAC    = 7;

  localparam logic [7:0]  TEMP_FAIL_LIMIT = 8'd3;
  localparam logic [16:0] OC_MARGIN_MA    = 17'd100;

  // Exact unsigned 32-bit division by 1000: (x * DIV1000_MULT) >> DIV1000_SHIFT.
  localparam logic [28:0] DIV1000_MULT  = 29'd274877907;
  localparam int          DIV1000_SHIFT = 38;

  // Register reset values.
  localparam logic [15:0]        VOLTAGE_LIMIT_RST     = 16'd30000;
  localparam logic [15:0]        CURRENT_LIMIT_RST     = 16'd5000;
  localparam logic [22:0]        POWER_ABS_LIMIT_RST   = 23'd35000;
  localparam logic [22:0]        POWER_CONT_LIMIT_RST  = 23'd25000;
  localparam logic signed [18:0] TEMP_TRIP_RST         = 19'sd85000;
  localparam logic signed [18:0] TEMP_CLEAR_RST        = 19'sd70000;
  localparam logic [15:0]        POWER_TRIP_TICKS_RST  = 16'd100;
  localparam logic [15:0]        TEMP_SAMPLE_TICKS_RST = 16'd10;

  typedef struct packed {
    logic [15:0]        voltage_limit_mv;
    logic [15:0]        current_limit_ma;
    logic [22:0]        power_abs_limit_mw;
    logic [22:0]        power_cont_limit_mw;
    logic signed [18:0] temp_trip_mc;
    logic signed [18:0] temp_clear_mc;
    logic [15:0]        power_trip_ticks;
    logic [15:0]        temp_sample_ticks;
  } lpc_cfg_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [15:0]        meas_current_ma;
    logic [15:0]        meas_voltage_mv;
    logic               reverse_flag;
    logic               overvolt_flag;
    logic               temp_read_ok;
    logic signed [18:0] temp_reading_mc;
    logic               dac_ok;
    logic [15:0]        setpoint_ma;
    logic               enable;
  } lpc_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  mode;
    logic [7:0]  fault_bits;
    logic        fault_latched;
    logic        output_on;
    logic        temp_valid;
    logic        drive_write;
    logic [15:0] drive_ma;
    logic [22:0] power_mw;
  } lpc_result_t;

endpackage

`default_nettype wire

// ----- rtl/core/lpc_if.sv -----
// ----------------------------------------------------------------------------
// lpc_in_if / lpc_out_if
// Valid/ready channels carrying command words and result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lpc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [15:0]        meas_current_ma;
  logic [15:0]        meas_voltage_mv;
  logic               reverse_flag;
  logic               overvolt_flag;
  logic               temp_read_ok;
  logic signed [18:0] temp_reading_mc;
  logic               dac_ok;
  logic [15:0]        setpoint_ma;
  logic               enable;

  modport source (
    output valid, cmd, meas_current_ma, meas_voltage_mv, reverse_flag, overvolt_flag,
           temp_read_ok, temp_reading_mc, dac_ok, setpoint_ma, enable,
    input  ready
  );
  modport sink (
    input  valid, cmd, meas_current_ma, meas_voltage_mv, reverse_flag, overvolt_flag,
           temp_read_ok, temp_reading_mc, dac_ok, setpoint_ma, enable,
    output ready
  );
endinterface

interface lpc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [1:0]  mode;
  logic [7:0]  fault_bits;
  logic        fault_latched;
  logic        output_on;
  logic        temp_valid;
  logic        drive_write;
  logic [15:0] drive_ma;
  logic [22:0] power_mw;

  modport source (
    output valid, status, mode, fault_bits, fault_latched, output_on, temp_valid,
           drive_write, drive_ma, power_mw,
    input  ready
  );
  modport sink (
    input  valid, status, mode, fault_bits, fault_latched, output_on, temp_valid,
           drive_write, drive_ma, power_mw,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/lpc_cfg.sv -----
// ----------------------------------------------------------------------------
// lpc_cfg
// Configuration register bank with write-only access.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpc_cfg
  import lpc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output lpc_cfg_t               cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.voltage_limit_mv    <= VOLTAGE_LIMIT_RST;
      cfg.current_limit_ma    <= CURRENT_LIMIT_RST;
      cfg.power_abs_limit_mw  <= POWER_ABS_LIMIT_RST;
      cfg.power_cont_limit_mw <= POWER_CONT_LIMIT_RST;
      cfg.temp_trip_mc        <= TEMP_TRIP_RST;
      cfg.temp_clear_mc       <= TEMP_CLEAR_RST;
      cfg.power_trip_ticks    <= POWER_TRIP_TICKS_RST;
      cfg.temp_sample_ticks   <= TEMP_SAMPLE_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VOLTAGE_LIMIT:     cfg.voltage_limit_mv    <= cfg_data[15:0];
        REG_CURRENT_LIMIT:     cfg.current_limit_ma    <= cfg_data[15:0];
        REG_POWER_ABS_LIMIT:   cfg.power_abs_limit_mw  <= cfg_data[22:0];
        REG_POWER_CONT_LIMIT:  cfg.power_cont_limit_mw <= cfg_data[22:0];
        REG_TEMP_TRIP:         cfg.temp_trip_mc        <= signed'(cfg_data[18:0]);
        REG_TEMP_CLEAR:        cfg.temp_clear_mc       <= signed'(cfg_data[18:0]);
        REG_POWER_TRIP_TICKS:  cfg.power_trip_ticks    <= cfg_data[15:0];
        REG_TEMP_SAMPLE_TICKS: cfg.temp_sample_ticks   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/lpc_power.sv -----
// ----------------------------------------------------------------------------
// lpc_power
// Two-stage power computation: current times voltage, then divide by 1000.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpc_power
  import lpc_pkg::*;
(
  input  logic        clk,
  input  logic        load1,
  input  logic        load2,
  input  lpc_item_t   item_in,
  output lpc_item_t   item_out,
  output logic [22:0] power_mw
);

  lpc_item_t   item1;
  logic [31:0] prod;
  logic [60:0] scaled;

  // The division uses a reciprocal multiply that is exact over 32-bit products.
  assign scaled = {29'd0, prod} * {32'd0, DIV1000_MULT};

  always_ff @(posedge clk) begin
    if (load1) begin
      item1 <= item_in;
      prod  <= {16'd0, item_in.meas_current_ma} * {16'd0, item_in.meas_voltage_mv};
    end
    if (load2) begin
      item_out <= item1;
      power_mw <= scaled[DIV1000_SHIFT+22:DIV1000_SHIFT];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/lpc_ctrl.sv -----
// ----------------------------------------------------------------------------
// lpc_ctrl
// Protection state, command handling and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpc_ctrl
  import lpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  lpc_item_t   item,
  input  logic [22:0] power_mw,
  input  lpc_cfg_t    cfg,
  output lpc_result_t res
);

  logic [1:0]         mode, mode_next;
  logic [15:0]        setpoint, setpoint_next;
  logic               output_flag, output_flag_next;
  logic               latch_flag, latch_flag_next;
  logic [7:0]         fault_word, fault_word_next;
  logic [15:0]        current_store, current_store_next;
  logic [15:0]        voltage_store, voltage_store_next;
  logic [22:0]        power_store, power_store_next;
  logic [1:0]         hw_fault_store, hw_fault_store_next;
  logic signed [18:0] temp_store, temp_store_next;
  logic               temp_valid_flag, temp_valid_flag_next;
  logic [7:0]         temp_fail_count, temp_fail_count_next;
  logic [15:0]        sample_counter, sample_counter_next;
  logic [15:0]        overpower_counter, overpower_counter_next;
  lpc_result_t        res_next;

  function automatic logic [7:0] active_faults(
    input logic [1:0]         hw,
    input logic [15:0]        volt,
    input logic [15:0]        cur,
    input logic [22:0]        pwr,
    input logic               tv,
    input logic signed [18:0] temp,
    input logic [7:0]         fails,
    input lpc_cfg_t           c
  );
    logic [7:0] a;
    a            = '0;
    a[FB_REV]    = hw[0];
    a[FB_OVHW]   = hw[1];
    a[FB_OVSW]   = volt > c.voltage_limit_mv;
    a[FB_OC]     = {1'b0, cur} > ({1'b0, c.current_limit_ma} + OC_MARGIN_MA);
    a[FB_POWER]  = pwr > c.power_abs_limit_mw;
    a[FB_OTEMP]  = tv && (temp >= c.temp_trip_mc);
    a[FB_SENSOR] = !tv && (fails >= TEMP_FAIL_LIMIT);
    return a;
  endfunction

  always_comb begin
    logic               rd_tv;
    logic [7:0]         rd_fc;
    logic signed [18:0] rd_temp;
    logic [7:0]         fc_inc;
    logic [15:0]        sc_inc;
    logic [1:0]         hw_now;
    logic [7:0]         act;

    mode_next              = mode;
    setpoint_next          = setpoint;
    output_flag_next       = output_flag;
    latch_flag_next        = latch_flag;
    fault_word_next        = fault_word;
    current_store_next     = current_store;
    voltage_store_next     = voltage_store;
    power_store_next       = power_store;
    hw_fault_store_next    = hw_fault_store;
    temp_store_next        = temp_store;
    temp_valid_flag_next   = temp_valid_flag;
    temp_fail_count_next   = temp_fail_count;
    sample_counter_next    = sample_counter;
    overpower_counter_next = overpower_counter;

    res_next.status      = ST_ACCEPTED;
    res_next.drive_write = 1'b0;
    res_next.drive_ma    = '0;

    // Outcome of a sensor read made by this command.
    fc_inc  = (temp_fail_count != 8'hFF) ? temp_fail_count + 8'd1 : temp_fail_count;
    rd_temp = item.temp_read_ok ? item.temp_reading_mc : temp_store;
    rd_fc   = item.temp_read_ok ? 8'd0 : fc_inc;
    rd_tv   = item.temp_read_ok ? 1'b1
            : ((fc_inc >= TEMP_FAIL_LIMIT) ? 1'b0 : temp_valid_flag);

    hw_now = {item.overvolt_flag, item.reverse_flag};
    sc_inc = (sample_counter != 16'hFFFF) ? sample_counter + 16'd1 : sample_counter;
    act    = '0;

    unique case (item.cmd)
      CMD_TICK: begin
        hw_fault_store_next = hw_now;
        current_store_next  = item.meas_current_ma;
        voltage_store_next  = item.meas_voltage_mv;
        power_store_next    = power_mw;

        if (sc_inc >= cfg.temp_sample_ticks) begin
          sample_counter_next  = '0;
          temp_store_next      = rd_temp;
          temp_valid_flag_next = rd_tv;
          temp_fail_count_next = rd_fc;
        end else begin
          sample_counter_next = sc_inc;
        end

        if (power_mw > cfg.power_cont_limit_mw) begin
          if (overpower_counter < cfg.power_trip_ticks) begin
            overpower_counter_next = overpower_counter + 16'd1;
          end
        end else begin
          overpower_counter_next = '0;
        end

        act = active_faults(hw_now, item.meas_voltage_mv, item.meas_current_ma, power_mw,
                            temp_valid_flag_next, temp_store_next, temp_fail_count_next, cfg);
        if (overpower_counter_next >= cfg.power_trip_ticks) begin
          act[FB_POWER] = 1'b1;
        end

        res_next.drive_write = 1'b1;
        if (act != 8'd0) begin
          mode_next        = MODE_FAULT;
          output_flag_next = 1'b0;
          latch_flag_next  = 1'b1;
          fault_word_next  = fault_word | act;
        end else if (latch_flag) begin
          mode_next = MODE_FAULT;
        end else if (!output_flag) begin
          mode_next = MODE_IDLE;
        end else if (!item.dac_ok) begin
          // The setpoint write failed, so the output is forced off again.
          mode_next                = MODE_FAULT;
          output_flag_next         = 1'b0;
          latch_flag_next          = 1'b1;
          fault_word_next          = fault_word;
          fault_word_next[FB_DAC]  = 1'b1;
        end else begin
          mode_next         = MODE_CC;
          res_next.drive_ma = setpoint;
        end
      end

      CMD_SET_CURRENT: begin
        if (item.setpoint_ma > cfg.current_limit_ma) begin
          res_next.status = ST_REJECTED;
        end else begin
          setpoint_next = item.setpoint_ma;
          if (output_flag && !latch_flag) begin
            res_next.drive_write = 1'b1;
            res_next.drive_ma    = item.setpoint_ma;
            res_next.status      = item.dac_ok ? ST_ACCEPTED : ST_DAC_FAIL;
          end
        end
      end

      CMD_ENABLE: begin
        if (!item.enable) begin
          output_flag_next     = 1'b0;
          mode_next            = MODE_IDLE;
          res_next.drive_write = 1'b1;
        end else if (latch_flag || !temp_valid_flag || (temp_store >= cfg.temp_trip_mc)) begin
          res_next.status = ST_REJECTED;
        end else begin
          output_flag_next     = 1'b1;
          res_next.drive_write = 1'b1;
          res_next.drive_ma    = setpoint;
          res_next.status      = item.dac_ok ? ST_ACCEPTED : ST_DAC_FAIL;
        end
      end

      CMD_CLEAR: begin
        // The hardware flags and the sensor read take effect even on a refusal.
        hw_fault_store_next  = hw_now;
        temp_store_next      = rd_temp;
        temp_valid_flag_next = rd_tv;
        temp_fail_count_next = rd_fc;
        act = active_faults(hw_now, voltage_store, current_store, power_store,
                            rd_tv, rd_temp, rd_fc, cfg);
        if (!rd_tv || (rd_temp > cfg.temp_clear_mc) || (act != 8'd0)) begin
          res_next.status = ST_REJECTED;
        end else begin
          latch_flag_next        = 1'b0;
          fault_word_next        = '0;
          output_flag_next       = 1'b0;
          mode_next              = MODE_IDLE;
          overpower_counter_next = '0;
          res_next.drive_write   = 1'b1;
        end
      end

      default: ;
    endcase

    res_next.mode          = mode_next;
    res_next.fault_bits    = fault_word_next;
    res_next.fault_latched = latch_flag_next;
    res_next.output_on     = output_flag_next;
    res_next.temp_valid    = temp_valid_flag_next;
    res_next.power_mw      = power_store_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= MODE_OFF;
      setpoint          <= '0;
      output_flag       <= 1'b0;
      latch_flag        <= 1'b0;
      fault_word        <= '0;
      current_store     <= '0;
      voltage_store     <= '0;
      power_store       <= '0;
      hw_fault_store    <= '0;
      temp_store        <= '0;
      temp_valid_flag   <= 1'b0;
      temp_fail_count   <= '0;
      sample_counter    <= '0;
      overpower_counter <= '0;
    end else if (take) begin
      mode              <= mode_next;
      setpoint          <= setpoint_next;
      output_flag       <= output_flag_next;
      latch_flag        <= latch_flag_next;
      fault_word        <= fault_word_next;
      current_store     <= current_store_next;
      voltage_store     <= voltage_store_next;
      power_store       <= power_store_next;
      hw_fault_store    <= hw_fault_store_next;
      temp_store        <= temp_store_next;
      temp_valid_flag   <= temp_valid_flag_next;
      temp_fail_count   <= temp_fail_count_next;
      sample_counter    <= sample_counter_next;
      overpower_counter <= overpower_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/load_protection_controller.sv -----
// Path: a command word accepted into stage 1 moves through stage 2 into the result register.
// Throughput: one command word per cycle, sustained, while the result side keeps up.
// The rate is set by the three-register pipeline (product, divide, state update).
// Reset: synchronous active-high rst clears the pipeline, the protection state and
// reloads every configuration register with its default value.
// ----------------------------------------------------------------------------
// load_protection_controller
// Protection and mode controller for a constant-current load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module load_protection_controller
  import lpc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  lpc_in_if.sink                 in_ch,
  lpc_out_if.source              out_ch,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // The pipeline has three registered stages:
  //   stage 1 holds the command word and the current-voltage product,
  //   stage 2 holds the word and the power after division by 1000,
  //   the output stage holds the result word; the protection state is
  //   updated in the same edge that loads it.
  // Power depends only on the word's own measurements, so stages 1 and 2
  // never need the state and the state update sees words strictly in order.
  // Each stage loads whenever it is empty or its content moves on, so a
  // stalled result still lets up to two more words be taken in.

  lpc_cfg_t    cfg;
  lpc_item_t   item_in;
  lpc_item_t   item2;
  logic [22:0] power2;
  lpc_result_t res;

  logic v1, v2, vo;
  logic adv1, adv2, advo;
  logic take;

  assign advo = !vo || out_ch.ready;
  assign adv2 = !v2 || advo;
  assign adv1 = !v1 || adv2;
  assign take = v2 && advo;

  assign in_ch.ready = adv1;

  assign item_in.cmd             = in_ch.cmd;
  assign item_in.meas_current_ma = in_ch.meas_current_ma;
  assign item_in.meas_voltage_mv = in_ch.meas_voltage_mv;
  assign item_in.reverse_flag    = in_ch.reverse_flag;
  assign item_in.overvolt_flag   = in_ch.overvolt_flag;
  assign item_in.temp_read_ok    = in_ch.temp_read_ok;
  assign item_in.temp_reading_mc = in_ch.temp_reading_mc;
  assign item_in.dac_ok          = in_ch.dac_ok;
  assign item_in.setpoint_ma     = in_ch.setpoint_ma;
  assign item_in.enable          = in_ch.enable;

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= in_ch.valid;
      end
      if (adv2) begin
        v2 <= v1;
      end
      if (advo) begin
        vo <= v2;
      end
    end
  end

  lpc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lpc_power u_power (
    .clk      (clk),
    .load1    (adv1),
    .load2    (adv2),
    .item_in  (item_in),
    .item_out (item2),
    .power_mw (power2)
  );

  lpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .item     (item2),
    .power_mw (power2),
    .cfg      (cfg),
    .res      (res)
  );

  assign out_ch.valid         = vo;
  assign out_ch.status        = res.status;
  assign out_ch.mode          = res.mode;
  assign out_ch.fault_bits    = res.fault_bits;
  assign out_ch.fault_latched = res.fault_latched;
  assign out_ch.output_on     = res.output_on;
  assign out_ch.temp_valid    = res.temp_valid;
  assign out_ch.drive_write   = res.drive_write;
  assign out_ch.drive_ma      = res.drive_ma;
  assign out_ch.power_mw      = res.power_mw;

  // The output can only be on while no fault is latched.
  `LPC_ASSERT_IMP(a_on_not_latched, clk, rst, vo && res.output_on, !res.fault_latched,
    "output enabled while a fault is latched")

  // A latched fault always names at least one cause.
  `LPC_ASSERT_IMP(a_latch_has_bits, clk, rst, vo && res.fault_latched, res.fault_bits != 8'd0,
    "fault latched with an empty fault word")

  // Constant-current mode requires the output to be enabled.
  `LPC_ASSERT_IMP(a_cc_needs_on, clk, rst, vo && (res.mode == MODE_CC), res.output_on,
    "constant-current mode with the output disabled")

  // A nonzero drive value is only reported together with a DAC write.
  `LPC_ASSERT_IMP(a_drive_written, clk, rst, vo && (res.drive_ma != 16'd0), res.drive_write,
    "drive value reported without a DAC write")

  // A word leaving stage 2 shows up as a valid result on the next cycle.
  `LPC_ASSERT_NEXT(a_stage_to_out, clk, rst, take, vo,
    "word from stage 2 did not reach the output register")

endmodule

`default_nettype wire
